// ===== sv/wsa_pkg.sv =====
// Shared types, constants and tables for the window sum/average accumulator.
// No dependencies; every other file of the block imports this package.
package wsa_pkg;

	localparam int DEPTH_DEFAULT = 256;
	localparam int VAL_W = 64;
	localparam int MAX_SCALE = 18;

	// Configuration register indexes.
	localparam logic [1:0] CFG_AVERAGE  = 2'd0;
	localparam logic [1:0] CFG_DISTINCT = 2'd1;
	localparam logic [1:0] CFG_SIGNED   = 2'd2;
	localparam logic [1:0] CFG_SCALE    = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SUM_OVF  = 2'd1;
	localparam logic [1:0] ST_AVG_OVF  = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// Search transaction that travels down the row of distinct cells.
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [VAL_W-1:0] val;
	} tok_t;

	// Powers of ten for scaling the average.
	function automatic logic [63:0] pow10(input logic [4:0] sc);
		logic [63:0] p;
		p = 64'd1;
		case (sc)
			5'd0: p = 64'd1;
			5'd1: p = 64'd10;
			5'd2: p = 64'd100;
			5'd3: p = 64'd1000;
			5'd4: p = 64'd10000;
			5'd5: p = 64'd100000;
			5'd6: p = 64'd1000000;
			5'd7: p = 64'd10000000;
			5'd8: p = 64'd100000000;
			5'd9: p = 64'd1000000000;
			5'd10: p = 64'd10000000000;
			5'd11: p = 64'd100000000000;
			5'd12: p = 64'd1000000000000;
			5'd13: p = 64'd10000000000000;
			5'd14: p = 64'd100000000000000;
			5'd15: p = 64'd1000000000000000;
			5'd16: p = 64'd10000000000000000;
			5'd17: p = 64'd100000000000000000;
			default: p = 64'd1000000000000000000;
		endcase
		return p;
	endfunction

endpackage

// ===== sv/window_sum_avg_accumulator.sv =====
// Window SUM/AVG accumulator with an optional DISTINCT store held in a row of cells.
// A value passes the accumulate state, in distinct mode after a search that walks the
// whole cell row; a frame end adds the frame and emit states, and for an average also
// the multiply and 128-step divider. One item at a time; the result register frees the input.
// Reset clears configuration to defaults, sum, count, fill and error; store contents stay.
module window_sum_avg_accumulator
	import wsa_pkg::*;
#(
	parameter int DISTINCT_DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] value,
	input  logic        is_null,
	input  logic        frame_end,
	input  logic        clear,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_value,
	output logic        result_null,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_wdata
);

	localparam int FW = $clog2(DISTINCT_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_ACCUM, S_FRAME, S_AVG, S_CHK, S_EMIT
	} state_t;

	state_t         state_q;
	logic           avg_mode_q, dist_mode_q, sgn_mode_q;
	logic [4:0]     scale_q;
	logic [63:0]    sum_q, cnt_q, val_q;
	logic [FW-1:0]  fill_q;
	logic [1:0]     err_q;
	logic           fe_q, hit_q, neg_q, avg_go_q;
	logic [63:0]    res_val_q;
	logic           res_null_q;
	logic           out_valid_q;
	logic [63:0]    out_val_q;
	logic           out_null_q;
	logic [1:0]     out_st_q;
	logic           feed_vld_q;
	logic [63:0]    feed_val_q;
	tok_t           chain [0:DISTINCT_DEPTH];
	logic           wr_en;
	logic           accept;
	logic           do_acc;
	logic [64:0]    add;
	logic           ovf;
	logic           full;
	logic [63:0]    mag;
	logic [4:0]     sc;
	logic           avg_done;
	logic [127:0]   avg_quo;
	logic           avg_bad;

	assign accept = in_valid && in_ready;
	assign in_ready = state_q == S_IDLE;
	assign do_acc = !is_null && (clear || err_q == ST_OK);

	// Add with overflow check in the selected signedness.
	assign add = {1'b0, sum_q} + {1'b0, val_q};
	assign ovf = sgn_mode_q ? (sum_q[63] == val_q[63] && add[63] != sum_q[63]) : add[64];
	assign full = fill_q == FW'(DISTINCT_DEPTH);
	assign wr_en = state_q == S_ACCUM && dist_mode_q && !hit_q && !full && !ovf;

	// Magnitude and scale for the average.
	assign mag = (sgn_mode_q && sum_q[63]) ? (64'd0 - sum_q) : sum_q;
	assign sc = (scale_q > 5'(MAX_SCALE)) ? 5'(MAX_SCALE) : scale_q;

	// Range check of the rounded average.
	always_comb begin
		avg_bad = avg_quo[127:64] != 64'd0;
		if (sgn_mode_q) begin
			if (neg_q) begin
				avg_bad = avg_bad || avg_quo[63:0] > 64'h8000000000000000;
			end else begin
				avg_bad = avg_bad || avg_quo[63];
			end
		end
	end

	// Row of distinct cells; a search enters at the first cell.
	assign chain[0] = {feed_vld_q, 1'b0, feed_val_q};
	for (genvar i = 0; i < DISTINCT_DEPTH; i++) begin : g_cell
		wsa_cell #(.IDX(i), .FW(FW)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.tok_in(chain[i]),
			.fill(fill_q),
			.wr_en(wr_en),
			.wr_data(val_q),
			.tok_out(chain[i+1])
		);
	end

	wsa_avg u_avg (
		.clk(clk),
		.arst_n(arst_n),
		.start(avg_go_q),
		.mag(mag),
		.mult(pow10(sc)),
		.divisor(cnt_q),
		.done(avg_done),
		.quo(avg_quo)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_mode_q <= 1'b0;
			dist_mode_q <= 1'b0;
			sgn_mode_q <= 1'b1;
			scale_q <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AVERAGE: avg_mode_q <= cfg_wdata[0];
				CFG_DISTINCT: dist_mode_q <= cfg_wdata[0];
				CFG_SIGNED: sgn_mode_q <= cfg_wdata[0];
				CFG_SCALE: scale_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Item payload latch.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
		end
		feed_val_q <= accept ? value : val_q;
	end

	// Control sequencer, accumulator state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_q <= 64'd0;
			cnt_q <= 64'd0;
			fill_q <= '0;
			err_q <= ST_OK;
			fe_q <= 1'b0;
			hit_q <= 1'b0;
			neg_q <= 1'b0;
			avg_go_q <= 1'b0;
			feed_vld_q <= 1'b0;
			res_val_q <= 64'd0;
			res_null_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_val_q <= 64'd0;
			out_null_q <= 1'b0;
			out_st_q <= ST_OK;
		end else begin
			// A search starts with an accepted, accumulable value in distinct mode.
			feed_vld_q <= accept && do_acc && dist_mode_q;
			// The average unit starts on a frame end that needs an average.
			avg_go_q <= state_q == S_FRAME && err_q == ST_OK && cnt_q != 64'd0 && avg_mode_q;
			if (out_ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						fe_q <= frame_end;
						hit_q <= 1'b0;
						if (clear) begin
							sum_q <= 64'd0;
							cnt_q <= 64'd0;
							fill_q <= '0;
							err_q <= ST_OK;
						end
						if (do_acc && dist_mode_q) begin
							state_q <= S_SEARCH;
						end else if (do_acc) begin
							state_q <= S_ACCUM;
						end else if (frame_end) begin
							state_q <= S_FRAME;
						end
					end
				end
				S_SEARCH: begin
					if (chain[DISTINCT_DEPTH].vld) begin
						hit_q <= chain[DISTINCT_DEPTH].hit;
						state_q <= S_ACCUM;
					end
				end
				S_ACCUM: begin
					if (dist_mode_q && hit_q) begin
						// Duplicate: skipped without any check.
					end else if (dist_mode_q && full) begin
						err_q <= ST_FULL;
					end else if (ovf) begin
						err_q <= ST_SUM_OVF;
					end else begin
						sum_q <= add[63:0];
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + 64'd1;
						end
						if (dist_mode_q) begin
							fill_q <= fill_q + FW'(1);
						end
					end
					state_q <= fe_q ? S_FRAME : S_IDLE;
				end
				S_FRAME: begin
					res_val_q <= 64'd0;
					res_null_q <= 1'b0;
					state_q <= S_EMIT;
					if (err_q != ST_OK) begin
						// Sticky error: zero result, status carries the error.
					end else if (cnt_q == 64'd0) begin
						res_null_q <= 1'b1;
					end else if (avg_mode_q) begin
						neg_q <= sgn_mode_q && sum_q[63];
						state_q <= S_AVG;
					end else begin
						res_val_q <= sum_q;
					end
				end
				S_AVG: begin
					if (avg_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (avg_bad) begin
						err_q <= ST_AVG_OVF;
					end else begin
						res_val_q <= neg_q ? (64'd0 - avg_quo[63:0]) : avg_quo[63:0];
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_val_q <= res_val_q;
						out_null_q <= res_null_q;
						out_st_q <= err_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result_value = out_val_q;
	assign result_null = out_null_q;
	assign status = out_st_q;

	// The fill count never passes the store depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DISTINCT_DEPTH))
		else $error("distinct fill beyond depth");

	// An error transaction carries a zero value and no null flag.
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result_value == 64'd0 && !result_null)
		else $error("error result not cleared");

	// An empty count means an empty sum.
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 64'd0 |-> sum_q == 64'd0)
		else $error("sum without count");

endmodule

// ===== sv/wsa_cell.sv =====
// One cell of the distinct store: holds one entry and checks a passing search.
// Depends on wsa_pkg for the search transaction type.
module wsa_cell
	import wsa_pkg::*;
#(
	parameter int IDX = 0,
	parameter int FW = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tok_t             tok_in,
	input  logic [FW-1:0]    fill,
	input  logic             wr_en,
	input  logic [VAL_W-1:0] wr_data,
	output tok_t             tok_out
);

	logic [VAL_W-1:0] entry_q;
	logic             vld_q;
	logic             hit_q;
	logic [VAL_W-1:0] val_q;
	logic             live;

	assign live = FW'(IDX) < fill;

	// The entry is written when the fill count points at this cell.
	always_ff @(posedge clk) begin
		if (wr_en && fill == FW'(IDX)) begin
			entry_q <= wr_data;
		end
	end

	// Pass the search on, marking a hit on a live matching entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			vld_q <= tok_in.vld;
			hit_q <= tok_in.hit | (tok_in.vld && live && entry_q == tok_in.val);
		end
	end

	always_ff @(posedge clk) begin
		val_q <= tok_in.val;
	end

	assign tok_out = {vld_q, hit_q, val_q};

endmodule

// ===== sv/wsa_avg.sv =====
// Scaled average unit: 64x64 multiply in 32-bit partial products, then a
// one-bit-per-cycle 128/64 restoring division and round half away from zero.
// Depends on wsa_pkg.
module wsa_avg
	import wsa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  mag,
	input  logic [63:0]  mult,
	input  logic [63:0]  divisor,
	output logic         done,
	output logic [127:0] quo
);

	typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_RND} avg_st_t;

	avg_st_t      state_q;
	logic [2:0]   k_q;
	logic [6:0]   cnt_q;
	logic [63:0]  prod_s1;
	logic [1:0]   sh_s1;
	logic [127:0] acc_q;
	logic [63:0]  rem_q;
	logic [127:0] quo_q;
	logic         done_q;
	logic [31:0]  a_part, b_part;
	logic [127:0] acc_next;
	logic [64:0]  rem_sh;
	logic         ge;
	logic [63:0]  rem_sub;
	logic         up;

	// Partial product operands picked by the step count.
	assign a_part = k_q[1] ? mag[63:32] : mag[31:0];
	assign b_part = k_q[0] ? mult[63:32] : mult[31:0];
	assign acc_next = acc_q + ({64'd0, prod_s1} << (7'd32 * {5'd0, sh_s1}));

	// Restoring division step.
	assign rem_sh = {rem_q, acc_q[127]};
	assign ge = rem_sh >= {1'b0, divisor};
	assign rem_sub = rem_sh[63:0] - divisor;
	assign up = rem_q >= (divisor - rem_q);

	always_ff @(posedge clk) begin
		prod_s1 <= {32'd0, a_part} * {32'd0, b_part};
		sh_s1 <= {1'b0, k_q[1]} + {1'b0, k_q[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			k_q <= 3'd0;
			cnt_q <= 7'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (start) begin
						state_q <= A_MUL;
						k_q <= 3'd0;
					end
				end
				A_MUL: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4) begin
						state_q <= A_DIV;
						cnt_q <= 7'd0;
					end
				end
				A_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) begin
						state_q <= A_RND;
					end
				end
				A_RND: begin
					done_q <= 1'b1;
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	// Datapath registers of the multiply and divide.
	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				acc_q <= 128'd0;
				rem_q <= 64'd0;
			end
			A_MUL: begin
				if (k_q != 3'd0) begin
					acc_q <= acc_next;
				end
			end
			A_DIV: begin
				rem_q <= ge ? rem_sub : rem_sh[63:0];
				acc_q <= {acc_q[126:0], ge};
			end
			A_RND: begin
				quo_q <= acc_q + {127'd0, up};
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule
